// ===== rtl/core/urrb_pkg.sv =====
// Shared types and constants for the UART receive ring buffer.
package urrb_pkg;

	localparam int DEPTH_DEFAULT = 64;
	localparam int BYTE_W        = 8;
	localparam int COUNT_W       = 32;

	// request kind codes
	localparam logic [1:0] KIND_RX    = 2'd0;
	localparam logic [1:0] KIND_READ  = 2'd1;
	localparam logic [1:0] KIND_CLEAR = 2'd2;

	typedef struct packed {
		logic [1:0]        kind;
		logic [BYTE_W-1:0] line_byte;
		logic              line_byte_valid;
	} req_t;

	typedef struct packed {
		logic [BYTE_W-1:0]  read_byte;
		logic               read_valid;
		logic               available;
		logic [COUNT_W-1:0] overrun_count;
	} res_t;

endpackage

// ===== rtl/core/urrb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module urrb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/core/uart_rx_ring_buffer_core.sv =====
// Top level of the UART receive ring buffer with overrun counter.
//
// A request is taken on every clock edge where start is high; busy never
// rises, so one request per cycle is sustained. Each request produces exactly
// one result, shown for one cycle with result_valid high, in the cycle right
// after the request was taken. The receiver cannot stall: the
// result is gone after that cycle. Pointers and the overrun counter update at
// the accept edge; the ring storage is a RAM whose registered read port
// delivers a popped byte in the result cycle. The ring holds DEPTH-1 bytes.
// A receive event with the ring full drops the byte and bumps the wrapping
// 32-bit overrun count. A read of an empty ring returns the receiver's byte
// when line_byte_valid is set. A clear zeroes both pointers and the count.
// RAM contents are not reset; only written slots are ever read.
module uart_rx_ring_buffer_core #(
	parameter int DEPTH = urrb_pkg::DEPTH_DEFAULT
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  urrb_pkg::req_t req,
	output logic           result_valid,
	output urrb_pkg::res_t result
);
	import urrb_pkg::*;

	localparam int PtrW = $clog2(DEPTH);
	localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);

	function automatic logic [PtrW-1:0] advance(input logic [PtrW-1:0] p);
		advance = (p == PtrLast) ? '0 : p + 1'b1;
	endfunction

	logic               accept;
	logic [PtrW-1:0]    wr_ptr_q, rd_ptr_q, wr_ptr_d, rd_ptr_d, wr_ptr_nxt;
	logic [COUNT_W-1:0] count_q, count_d;
	logic               is_rx, is_read, is_clear;
	logic               full, empty;
	logic               push, drop, pop, fall;

	logic               valid_s1, pop_s1, fall_s1, avail_s1;
	logic [BYTE_W-1:0]  byte_s1;
	logic [BYTE_W-1:0]  ram_rdata;

	assign busy   = 1'b0;
	assign accept = start & ~busy;

	// decode and next-state for pointers and counter
	always_comb begin
		is_rx      = req.kind == KIND_RX;
		is_read    = req.kind == KIND_READ;
		is_clear   = req.kind == KIND_CLEAR;
		wr_ptr_nxt = advance(wr_ptr_q);
		full       = wr_ptr_nxt == rd_ptr_q;
		empty      = wr_ptr_q == rd_ptr_q;
		push       = accept & is_rx & req.line_byte_valid & ~full;
		drop       = accept & is_rx & req.line_byte_valid & full;
		pop        = accept & is_read & ~empty;
		fall       = accept & is_read & empty & req.line_byte_valid;

		wr_ptr_d = wr_ptr_q;
		rd_ptr_d = rd_ptr_q;
		count_d  = count_q;
		if (accept && is_clear) begin
			wr_ptr_d = '0;
			rd_ptr_d = '0;
			count_d  = '0;
		end else begin
			if (push) begin
				wr_ptr_d = wr_ptr_nxt;
			end
			if (pop) begin
				rd_ptr_d = advance(rd_ptr_q);
			end
			if (drop) begin
				count_d = count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
			valid_s1 <= 1'b0;
			pop_s1   <= 1'b0;
			fall_s1  <= 1'b0;
			avail_s1 <= 1'b0;
		end else begin
			wr_ptr_q <= wr_ptr_d;
			rd_ptr_q <= rd_ptr_d;
			count_q  <= count_d;
			valid_s1 <= accept;
			pop_s1   <= pop;
			fall_s1  <= fall;
			avail_s1 <= (wr_ptr_d != rd_ptr_d) | req.line_byte_valid;
		end
	end

	// fall-through byte, payload only
	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= req.line_byte;
		end
	end

	// ring storage: push writes at the write pointer, pop reads at the read pointer
	urrb_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(DEPTH)
	) u_ring (
		.clk  (clk),
		.we   (push),
		.waddr(wr_ptr_q),
		.wdata(req.line_byte),
		.re   (pop),
		.raddr(rd_ptr_q),
		.rdata(ram_rdata)
	);

	always_comb begin
		result_valid         = valid_s1;
		result.read_valid    = pop_s1 | fall_s1;
		result.available     = avail_s1;
		result.overrun_count = count_q;
		if (pop_s1) begin
			result.read_byte = ram_rdata;
		end else if (fall_s1) begin
			result.read_byte = byte_s1;
		end else begin
			result.read_byte = '0;
		end
	end

	a_clear_zeroes: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_clear) |=> (wr_ptr_q == '0 && rd_ptr_q == '0 && count_q == '0))
		else $error("clear did not zero pointers and count");

	a_count_only_on_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(!drop && !(accept && is_clear)) |=> $stable(count_q))
		else $error("overrun count moved without a drop");

	a_pop_xor_fall: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop_s1 && fall_s1))
		else $error("pop and fall-through in the same result");

	a_result_follows_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> result_valid)
		else $error("request without result");

	a_never_full_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> (wr_ptr_q != rd_ptr_q))
		else $error("push left ring looking empty");

endmodule
